FILE: rtl/enms_pkg.sv
// ============================================================================
// enms_pkg
// Shared types, constants and helpers for the edge non-maximum suppression
// block: payload structs, register indexes, direction sectors.
// ============================================================================
package enms_pkg;

    localparam int MAG_W             = 16;
    localparam int ANG_W             = 11;
    localparam int WIDTH_REG_W       = 12;
    localparam int HEIGHT_REG_W      = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int ROW_W             = 13;   // row counter runs up to height + 1
    localparam int Y_W               = 12;   // centre row, 0 .. height - 1
    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int MAX_HEIGHT        = 4096;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // Angle boundaries in quarter degrees
    localparam logic [ANG_W-1:0] ANGLE_22P5  = 11'd90;
    localparam logic [ANG_W-1:0] ANGLE_67P5  = 11'd270;
    localparam logic [ANG_W-1:0] ANGLE_112P5 = 11'd450;
    localparam logic [ANG_W-1:0] ANGLE_157P5 = 11'd630;
    localparam logic [ANG_W-1:0] ANGLE_202P5 = 11'd810;
    localparam logic [ANG_W-1:0] ANGLE_247P5 = 11'd990;
    localparam logic [ANG_W-1:0] ANGLE_292P5 = 11'd1170;
    localparam logic [ANG_W-1:0] ANGLE_337P5 = 11'd1350;
    localparam logic [ANG_W-1:0] ANGLE_360   = 11'd1440;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Axis along which the centre is compared with its two neighbors
    typedef enum logic [1:0] {
        DIR_HORZ      = 2'd0,   // left / right
        DIR_DIAG_DOWN = 2'd1,   // down-right / up-left
        DIR_VERT      = 2'd2,   // below / above
        DIR_DIAG_UP   = 2'd3    // down-left / up-right
    } dir_t;

    typedef struct packed {
        logic [MAG_W-1:0] grad_magnitude;
        logic [ANG_W-1:0] grad_angle;
        logic             flush_item;
    } pixel_in_t;

    typedef struct packed {
        logic [MAG_W-1:0] thinned_magnitude;
        logic             frame_last;
    } pixel_out_t;

    // Which sides of the centre lie inside the image
    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic up_ok;
        logic down_ok;
    } border_t;

    typedef struct packed {
        logic    produce;
        logic    frame_last;
        border_t border;
    } s1_ctrl_t;

    // One line buffer entry: one row back and two rows back, same column
    typedef struct packed {
        logic [MAG_W-1:0] mag_row1;
        logic [MAG_W-1:0] mag_row2;
        logic [ANG_W-1:0] ang_row1;
    } line_entry_t;

    // 3x3 window, index = row * 3 + column, row 0 on top
    typedef logic [8:0][MAG_W-1:0] win_t;

    function automatic dir_t angle_to_dir(input logic [ANG_W-1:0] angle);
        logic [ANG_W-1:0] a;
        dir_t             d;
        a = (angle >= ANGLE_360) ? angle - ANGLE_360 : angle;
        if (a < ANGLE_22P5 || a >= ANGLE_337P5)
            d = DIR_HORZ;
        else if (a < ANGLE_67P5)
            d = DIR_DIAG_DOWN;
        else if (a < ANGLE_112P5)
            d = DIR_VERT;
        else if (a < ANGLE_157P5)
            d = DIR_DIAG_UP;
        else if (a < ANGLE_202P5)
            d = DIR_HORZ;
        else if (a < ANGLE_247P5)
            d = DIR_DIAG_DOWN;
        else if (a < ANGLE_292P5)
            d = DIR_VERT;
        else
            d = DIR_DIAG_UP;
        return d;
    endfunction

endpackage

FILE: rtl/edge_non_maximum_suppression.sv
// ============================================================================
// edge_non_maximum_suppression
// Canny-style non-maximum suppression on a raster stream of gradient
// magnitude and direction, one pixel per clock unless the result stalls.
// ============================================================================
// Pixels enter in raster order at up to one transaction per clock; the
// result stream follows the pixel stream one row plus one pixel behind, so
// after the last pixel of a frame the source sends image_width + 1 flush
// items to drain it (the result carrying frame_last closes the frame and the
// next item starts a new one). Flush items that arrive while pixels of the
// frame are still expected are swallowed without effect. Sustained rate is
// one item per clock while the result is not stalled. The result an item
// releases is registered in order: the input stage and the line buffer read
// register load when that item is accepted, then the result register loads
// as soon as it is free (a stalled result holds the input stage).
// The only memory is a single line buffer with one read and one write per
// clock; each entry holds the magnitude from one and two rows back plus the
// direction from one row back, so it needs no clearing pass after reset:
// entries not written in the current frame are only ever read for
// neighbors outside the image, which are masked to zero. Writing either
// size register restarts the frame; do so only while the block is idle.
// Widths above MAX_WIDTH are clamped to MAX_WIDTH, zero sizes count as one,
// heights above 4096 as 4096.
// ============================================================================
module edge_non_maximum_suppression #(
    parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  enms_pkg::pixel_in_t               pixel,

    output logic                              result_valid,
    input  logic                              result_ready,
    output enms_pkg::pixel_out_t              result,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  enms_pkg::cfg_reg_t                cfg_index,
    input  logic [enms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);       // column index
    localparam int WW     = $clog2(MAX_WIDTH + 1);   // width value
    localparam int LINE_W = $bits(enms_pkg::line_entry_t);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [enms_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [enms_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic                              cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= enms_pkg::WIDTH_RESET;
            height_reg <= enms_pkg::HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                enms_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[enms_pkg::WIDTH_REG_W-1:0];
                enms_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[enms_pkg::HEIGHT_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective frame size
    logic [WW-1:0]                     w_eff;
    logic [WW-1:0]                     w_m1;
    logic [enms_pkg::HEIGHT_REG_W-1:0] h_eff;
    logic [enms_pkg::Y_W-1:0]          h_m1;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = enms_pkg::HEIGHT_REG_W'(1);
        else if (height_reg > enms_pkg::MAX_HEIGHT)
            h_eff = enms_pkg::HEIGHT_REG_W'(enms_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign w_m1 = w_eff - WW'(1);
    assign h_m1 = enms_pkg::Y_W'(h_eff - enms_pkg::HEIGHT_REG_W'(1));

    // ------------------------------------------------------------------
    // Input side: position counters and center bookkeeping
    // ------------------------------------------------------------------
    // col/row give the frame position of the incoming item; the center it
    // releases sits one row plus one pixel earlier in raster order.
    logic [CW-1:0]              col_count_reg, col_count_next;
    logic [enms_pkg::ROW_W-1:0] row_count_reg, row_count_next;

    logic                       s1_valid_reg, s1_valid_next;
    enms_pkg::s1_ctrl_t         s1_ctrl_reg, s1_ctrl_next;
    logic [CW-1:0]              s1_col_reg;
    logic [enms_pkg::MAG_W-1:0] s1_mag_reg;
    logic [enms_pkg::ANG_W-1:0] s1_ang_reg;

    logic                       out_valid_reg, out_valid_next;
    enms_pkg::pixel_out_t       out_data_reg;
    enms_pkg::pixel_out_t       kernel_result;

    logic                       accept;
    logic                       in_image_phase;
    logic                       ignored;
    logic                       s1_load;
    logic                       s1_fire;
    logic                       col_nz;
    logic [CW-1:0]              centre_x;
    logic [enms_pkg::Y_W-1:0]   centre_y;

    // S1 moves on when it releases no result or the result register frees up
    assign s1_fire = s1_valid_reg
                  && (!s1_ctrl_reg.produce || !out_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_fire;
    assign accept      = pixel_valid && pixel_ready;

    assign in_image_phase = (row_count_reg < h_eff);
    assign ignored        = in_image_phase && pixel.flush_item;
    assign s1_load        = accept && !ignored;

    assign col_nz   = (col_count_reg != '0);
    assign centre_x = col_nz ? col_count_reg - CW'(1) : CW'(w_m1);
    assign centre_y = col_nz ? enms_pkg::Y_W'(row_count_reg - enms_pkg::ROW_W'(1))
                             : enms_pkg::Y_W'(row_count_reg - enms_pkg::ROW_W'(2));

    always_comb
    begin
        s1_ctrl_next.produce = (row_count_reg >= enms_pkg::ROW_W'(2))
                            || ((row_count_reg == enms_pkg::ROW_W'(1)) && col_nz);
        s1_ctrl_next.border.left_ok  = (centre_x != '0);
        s1_ctrl_next.border.right_ok = (WW'(centre_x) != w_m1);
        s1_ctrl_next.border.up_ok    = (centre_y != '0);
        s1_ctrl_next.border.down_ok  = (centre_y != h_m1);
        s1_ctrl_next.frame_last      = s1_ctrl_next.produce
                                    && !s1_ctrl_next.border.right_ok
                                    && !s1_ctrl_next.border.down_ok;
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_fire)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (s1_load)
        begin
            if (s1_ctrl_next.frame_last)
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (WW'(col_count_reg) == w_m1)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + enms_pkg::ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ctrl_reg   <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            if (s1_load)
                s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    // S1 payload (no reset)
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_col_reg <= col_count_reg;
            s1_mag_reg <= pixel.grad_magnitude;
            s1_ang_reg <= pixel.grad_angle;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: read at acceptance, written back when S1 moves on
    // ------------------------------------------------------------------
    logic [LINE_W-1:0]     rd_data;
    enms_pkg::line_entry_t rd_entry;
    enms_pkg::line_entry_t wr_entry;

    assign rd_entry          = enms_pkg::line_entry_t'(rd_data);
    assign wr_entry.mag_row1 = s1_mag_reg;
    assign wr_entry.mag_row2 = rd_entry.mag_row1;
    assign wr_entry.ang_row1 = s1_ang_reg;

    enms_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (s1_load),
        .rd_addr (col_count_reg),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (LINE_W'(wr_entry))
    );

    // ------------------------------------------------------------------
    // Window: left and middle columns in registers, right column is the
    // one S1 holds right now (rows y-1, y, y+1 = two back, one back, new)
    // ------------------------------------------------------------------
    logic [2:0][enms_pkg::MAG_W-1:0] left_col_reg;
    logic [2:0][enms_pkg::MAG_W-1:0] mid_col_reg;
    logic [2:0][enms_pkg::MAG_W-1:0] right_col;
    enms_pkg::dir_t                  centre_dir_reg;
    enms_pkg::win_t                  win;

    assign right_col[0] = rd_entry.mag_row2;
    assign right_col[1] = rd_entry.mag_row1;
    assign right_col[2] = s1_mag_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3]     = left_col_reg[r];
            win[r * 3 + 1] = mid_col_reg[r];
            win[r * 3 + 2] = right_col[r];
        end
    end

    // The center's direction was read one step earlier, as the row-above
    // direction of the column that is now the middle one.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            left_col_reg   <= mid_col_reg;
            mid_col_reg    <= right_col;
            centre_dir_reg <= enms_pkg::angle_to_dir(rd_entry.ang_row1);
        end
    end

    enms_kernel u_kernel (
        .win        (win),
        .dir        (centre_dir_reg),
        .border     (s1_ctrl_reg.border),
        .frame_last (s1_ctrl_reg.frame_last),
        .result     (kernel_result)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_ctrl_reg.produce)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctrl_reg.produce)
            out_data_reg <= kernel_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    // Column counter never passes the last column of the current width
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_count_reg) <= w_m1)
        else $error("column counter beyond image width");

    // Row counter stops at the drain row that closes the frame
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= h_eff + enms_pkg::HEIGHT_REG_W'(1))
        else $error("row counter beyond drain row");

    // A swallowed flush leaves the frame position alone
    a_flush_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ignored && !cfg_fire)
        |=> ($stable(col_count_reg) && $stable(row_count_reg)))
        else $error("ignored flush moved the frame position");

    // The item that releases the frame's last result restarts the frame
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && s1_ctrl_next.frame_last)
        |=> ((col_count_reg == '0) && (row_count_reg == '0)))
        else $error("frame did not restart after its last pixel");

    // S1 never hands a result to an occupied, stalled result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_ctrl_reg.produce) |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: rtl/enms_line_buf.sv
// ============================================================================
// enms_line_buf
// Line buffer: one write and one registered read per cycle, with the write
// data bypassed to the read when both hit the same entry in the same cycle.
// ============================================================================
module enms_line_buf #(
    parameter int DEPTH  = enms_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_W = $bits(enms_pkg::line_entry_t)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-during-write returns the new data (one-column images)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/enms_kernel.sv
// ============================================================================
// enms_kernel
// Suppression decision for one centre pixel: picks the two opposite
// neighbors along the quantized direction, zeroes those outside the image,
// and keeps the centre only if neither neighbor is larger.
// ============================================================================
module enms_kernel (
    input  enms_pkg::win_t      win,
    input  enms_pkg::dir_t      dir,
    input  enms_pkg::border_t   border,
    input  logic                frame_last,
    output enms_pkg::pixel_out_t result
);

    logic [enms_pkg::MAG_W-1:0] cur;
    logic [enms_pkg::MAG_W-1:0] n1;
    logic [enms_pkg::MAG_W-1:0] n2;
    logic                       n1_ok;
    logic                       n2_ok;

    assign cur = win[4];

    always_comb
    begin
        case (dir)
            enms_pkg::DIR_HORZ:
            begin
                n1    = win[5];
                n1_ok = border.right_ok;
                n2    = win[3];
                n2_ok = border.left_ok;
            end
            enms_pkg::DIR_DIAG_DOWN:
            begin
                n1    = win[8];
                n1_ok = border.down_ok && border.right_ok;
                n2    = win[0];
                n2_ok = border.up_ok && border.left_ok;
            end
            enms_pkg::DIR_VERT:
            begin
                n1    = win[7];
                n1_ok = border.down_ok;
                n2    = win[1];
                n2_ok = border.up_ok;
            end
            default:
            begin
                n1    = win[6];
                n1_ok = border.down_ok && border.left_ok;
                n2    = win[2];
                n2_ok = border.up_ok && border.right_ok;
            end
        endcase
    end

    always_comb
    begin
        result.frame_last = frame_last;
        if ((n1_ok && (cur < n1)) || (n2_ok && (cur < n2)))
            result.thinned_magnitude = '0;
        else
            result.thinned_magnitude = cur;
    end

endmodule
